FILE: rtl/dcl_pkg.sv
package dcl_pkg;

  // Default channel store depth per pixel.
  localparam int MAX_CHANNELS_DEF = 64;

  // Field and datapath widths.
  localparam int FEAT_W  = 16;
  localparam int D_W     = 17;  // signed element difference
  localparam int DM_W    = 16;  // magnitude of the difference
  localparam int CNT_W   = 7;   // channel count
  localparam int DSQ_W   = 41;  // squared distance accumulator
  localparam int LOSS_W  = 48;  // batch loss accumulator
  localparam int BL_W    = 47;  // normalized batch loss
  localparam int SQ_W    = 58;  // square root working width
  localparam int ROOT_W  = 29;  // distance in Q13.16
  localparam int MQ_W    = 24;  // margin in Q8.16
  localparam int DEN_W   = 30;  // distance plus epsilon
  localparam int R_W     = 48;  // gradient ratio
  localparam int GS_W    = 32;
  localparam int NS_W    = 16;
  localparam int MARG_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_A_W = 2;

  // Square root iteration setup.
  localparam int SQ_BIT0 = 56;
  localparam int SQ_ITER = 29;

  // Epsilon 1e-4 in Q16.16.
  localparam logic [DEN_W-1:0] EPS_Q = DEN_W'(7);

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_MARGIN     = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_GRAD_SCALE = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_NUM_SAMP   = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_CHANNELS   = 2'd3;

  // Finished pixel handed from the front end to the gradient engine.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [DSQ_W-1:0] dsq;
    logic [MQ_W-1:0]  m;
    logic             mpos;
    logic [DEN_W-1:0] den;
    logic             label;
    logic             last_b;
    logic [BL_W-1:0]  bl;
    logic             bank;
  } pix_desc_t;

endpackage

FILE: rtl/dcl_ram.sv
module dcl_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/dcl_div.sv
module dcl_div #(
  parameter int NW = 48,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[NW-2:0], ge};
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/dcl_front.sv
module dcl_front #(
  parameter int MAX_CHANNELS = dcl_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [dcl_pkg::FEAT_W-1:0]   in_feat_a,
  input  logic signed [dcl_pkg::FEAT_W-1:0]   in_feat_b,
  input  logic                                in_similar,
  input  logic                                in_last_of_batch,
  input  logic [dcl_pkg::MARG_W-1:0]          margin,
  input  logic [dcl_pkg::NS_W-1:0]            num_samples,
  input  logic [dcl_pkg::CNT_W-1:0]           channels_in_use,
  input  logic [1:0]                          q_count,
  output logic                                push,
  output dcl_pkg::pix_desc_t                  desc,
  output logic                                ram_we,
  output logic [$clog2(2*MAX_CHANNELS)-1:0]   ram_waddr,
  output logic [dcl_pkg::D_W-1:0]             ram_wdata
);

  import dcl_pkg::*;

  localparam int AW = $clog2(2 * MAX_CHANNELS);

  typedef enum logic [2:0] {F_ACC, F_SQRT, F_HINGE, F_LOSS, F_DIV} state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DSQ_W-1:0]    dist_r;
  logic                label_r;
  logic                bank_r;
  logic [LOSS_W-1:0]   loss_r;
  logic [CNT_W-1:0]    px_n_r;
  logic [DSQ_W-1:0]    px_dsq_r;
  logic                px_last_r;
  logic                px_bank_r;
  logic [MQ_W-1:0]     px_m_r;
  logic                px_mpos_r;
  logic [DEN_W-1:0]    px_den_r;
  logic [2*MQ_W-1:0]   hsq_r;
  logic [SQ_W-1:0]     sq_x_r;
  logic [SQ_W-1:0]     sq_r_r;
  logic [SQ_W-1:0]     sq_bit_r;
  logic [4:0]          sq_it_r;

  logic [CNT_W-1:0]    lim;
  logic                acc;
  logic signed [D_W-1:0] d;
  logic signed [2*D_W-1:0] d_sq;
  logic [DSQ_W-1:0]    dist_sum;
  logic [CNT_W-1:0]    cnt_inc;
  logic                px_end;
  logic                lab;
  logic [SQ_W-1:0]     sq_t;
  logic                sq_ge;
  logic [ROOT_W-1:0]   root;
  logic [MQ_W-1:0]     mq;
  logic                mpos;
  logic [MQ_W-1:0]     m;
  logic [DSQ_W-1:0]    term;
  logic [LOSS_W:0]     loss_sum;
  logic [LOSS_W-1:0]   loss_sat;
  logic [NS_W-1:0]     ns_eff;
  logic                div_start;
  logic                div_done;
  logic [LOSS_W-1:0]   div_q;

  // Channel limit, clamped to the store depth, with zero taken as one.
  always_comb begin
    if (channels_in_use == '0) begin
      lim = CNT_W'(1);
    end else if (channels_in_use > CNT_W'(MAX_CHANNELS)) begin
      lim = CNT_W'(MAX_CHANNELS);
    end else begin
      lim = channels_in_use;
    end
  end

  // Input word acceptance and distance accumulation.
  assign in_full  = (state_r != F_ACC) || (q_count == 2'd2);
  assign acc      = in_push && !in_full;
  assign d        = D_W'(in_feat_a) - D_W'(in_feat_b);
  assign d_sq     = d * d;
  assign dist_sum = dist_r + DSQ_W'(unsigned'(d_sq));
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign px_end   = (cnt_inc >= lim) || in_last_of_batch;
  assign lab      = (cnt_r == '0) ? in_similar : label_r;

  assign ram_we    = acc;
  assign ram_wdata = d;
  assign ram_waddr = bank_r ? AW'(MAX_CHANNELS) + AW'(cnt_r) : AW'(cnt_r);

  // Square root step.
  assign sq_t  = sq_r_r + sq_bit_r;
  assign sq_ge = sq_x_r >= sq_t;

  // Hinge operand from the finished root.
  assign root = sq_r_r[ROOT_W-1:0];
  assign mq   = {margin, 8'd0};
  assign mpos = ROOT_W'(mq) > root;
  assign m    = mpos ? mq - root[MQ_W-1:0] : '0;

  // Pixel loss term and saturating batch sum.
  always_comb begin
    if (label_r) begin
      term = px_dsq_r;
    end else if (px_mpos_r) begin
      term = DSQ_W'((({1'b0, hsq_r} + (2*MQ_W+1)'(32768)) >> 16));
    end else begin
      term = '0;
    end
  end
  assign loss_sum = {1'b0, loss_r} + (LOSS_W+1)'(term);
  assign loss_sat = loss_sum[LOSS_W] ? '1 : loss_sum[LOSS_W-1:0];
  assign ns_eff   = (num_samples == '0) ? NS_W'(1) : num_samples;

  assign div_start = (state_r == F_LOSS) && px_last_r;

  dcl_div #(.NW(LOSS_W), .DW(NS_W + 1)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (loss_sat),
    .divisor  ({ns_eff, 1'b0}),
    .done     (div_done),
    .quotient (div_q)
  );

  // Hand-off to the queue.
  assign push = ((state_r == F_LOSS) && !px_last_r) || ((state_r == F_DIV) && div_done);
  always_comb begin
    desc        = '0;
    desc.n      = px_n_r;
    desc.dsq    = px_dsq_r;
    desc.m      = px_m_r;
    desc.mpos   = px_mpos_r;
    desc.den    = px_den_r;
    desc.label  = label_r;
    desc.last_b = px_last_r;
    desc.bl     = (state_r == F_DIV) ? div_q[BL_W-1:0] : '0;
    desc.bank   = px_bank_r;
  end

  // Front end sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_ACC;
      cnt_r   <= '0;
      dist_r  <= '0;
      label_r <= 1'b0;
      bank_r  <= 1'b0;
      loss_r  <= '0;
    end else begin
      case (state_r)
        F_ACC: begin
          if (acc) begin
            label_r <= lab;
            if (px_end) begin
              px_n_r    <= cnt_inc;
              px_dsq_r  <= dist_sum;
              px_last_r <= in_last_of_batch;
              px_bank_r <= bank_r;
              bank_r    <= ~bank_r;
              cnt_r     <= '0;
              dist_r    <= '0;
              sq_x_r    <= SQ_W'({dist_sum, 16'd0});
              sq_r_r    <= '0;
              sq_bit_r  <= SQ_W'(1) << SQ_BIT0;
              sq_it_r   <= 5'(SQ_ITER);
              state_r   <= F_SQRT;
            end else begin
              cnt_r  <= cnt_inc;
              dist_r <= dist_sum;
            end
          end
        end
        F_SQRT: begin
          if (sq_ge) begin
            sq_x_r <= sq_x_r - sq_t;
            sq_r_r <= (sq_r_r >> 1) + sq_bit_r;
          end else begin
            sq_r_r <= sq_r_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          sq_it_r  <= sq_it_r - 5'd1;
          if (sq_it_r == 5'd1) begin
            state_r <= F_HINGE;
          end
        end
        F_HINGE: begin
          px_m_r    <= m;
          px_mpos_r <= mpos;
          px_den_r  <= DEN_W'(root) + EPS_Q;
          hsq_r     <= m * m;
          state_r   <= F_LOSS;
        end
        F_LOSS: begin
          loss_r <= loss_sat;
          if (px_last_r) begin
            state_r <= F_DIV;
          end else begin
            state_r <= F_ACC;
          end
        end
        F_DIV: begin
          if (div_done) begin
            loss_r  <= '0;
            state_r <= F_ACC;
          end
        end
        default: begin
          state_r <= F_ACC;
        end
      endcase
    end
  end

endmodule

FILE: rtl/dcl_back.sv
module dcl_back #(
  parameter int MAX_CHANNELS = dcl_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dcl_pkg::GS_W-1:0]          grad_scale,
  input  logic                              q_valid,
  input  dcl_pkg::pix_desc_t                desc,
  output logic                              pop,
  output logic [$clog2(2*MAX_CHANNELS)-1:0] ram_raddr,
  input  logic [dcl_pkg::D_W-1:0]           ram_rdata,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [31:0]                out_grad_a,
  output logic signed [31:0]                out_grad_b,
  output logic [39:0]                       out_pixel_dist_sq,
  output logic [46:0]                       out_batch_loss,
  output logic                              out_loss_valid,
  output logic                              out_last_of_pixel
);

  import dcl_pkg::*;

  localparam int AW    = $clog2(2 * MAX_CHANNELS);
  localparam int ACC_W = GS_W + R_W + 1;
  localparam int MAG_W = ACC_W - 16;

  typedef enum logic [2:0] {B_IDLE, B_RD, B_DAT, B_DIVS, B_DIVW, B_MUL, B_OUT} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   k_r;
  logic               dneg_r;
  logic [R_W-1:0]     r_r;
  logic [R_W-9:0]     prod_r;
  logic [ACC_W-1:0]   acc_r;
  logic [1:0]         mj_r;
  logic               ovalid_r;

  logic               gneg;
  logic [GS_W-1:0]    gsm;
  logic               dv_neg;
  logic [D_W-1:0]     dv_abs;
  logic [DM_W-1:0]    dm;
  logic               div_start;
  logic               div_done;
  logic [R_W-1:0]     div_q;
  logic [15:0]        chunk;
  logic [GS_W+15:0]   slice_prod;
  logic [MAG_W-1:0]   mag;
  logic               neg;
  logic [31:0]        ga;
  logic [31:0]        gb;
  logic               slot_free;
  logic               last_r;

  assign gneg = grad_scale[GS_W-1];
  assign gsm  = gneg ? GS_W'(0) - grad_scale : grad_scale;

  assign ram_raddr = desc.bank ? AW'(MAX_CHANNELS) + AW'(k_r) : AW'(k_r);

  // Magnitude of the stored difference.
  assign dv_neg = ram_rdata[D_W-1];
  assign dv_abs = dv_neg ? D_W'(0) - ram_rdata : ram_rdata;
  assign dm     = dv_abs[DM_W-1:0];

  // Ratio divider for dissimilar pairs.
  assign div_start = (state_r == B_DIVS);

  dcl_div #(.NW(R_W), .DW(DEN_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({prod_r, 8'd0}),
    .divisor  (desc.den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Scale multiply, one 16-bit slice of the ratio per cycle.
  assign chunk      = r_r[mj_r*16 +: 16];
  assign slice_prod = gsm * chunk;

  // Rounding, sign and saturation.
  assign mag = MAG_W'((acc_r + ACC_W'(32768)) >> 16);
  assign neg = desc.label ? (gneg != dneg_r) : (gneg == dneg_r);
  always_comb begin
    if (neg) begin
      ga = (mag >= MAG_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'd0 - mag[31:0];
      gb = (mag > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      ga = (mag > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
      gb = (mag >= MAG_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'd0 - mag[31:0];
    end
  end

  assign slot_free = !ovalid_r || out_pop;
  assign last_r    = (k_r == desc.n - CNT_W'(1));
  assign pop       = (state_r == B_OUT) && slot_free && last_r;
  assign out_empty = !ovalid_r;

  // Gradient engine sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      k_r      <= '0;
      mj_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if ((state_r == B_OUT) && slot_free) begin
        ovalid_r <= 1'b1;
      end else if (out_pop) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            k_r     <= '0;
            state_r <= B_RD;
          end
        end
        B_RD: begin
          state_r <= B_DAT;
        end
        B_DAT: begin
          dneg_r <= dv_neg;
          acc_r  <= '0;
          mj_r   <= 2'd2;
          if (desc.label) begin
            r_r     <= R_W'({dm, 8'd0});
            state_r <= B_MUL;
          end else if (desc.mpos) begin
            prod_r  <= desc.m * dm;
            state_r <= B_DIVS;
          end else begin
            r_r     <= '0;
            state_r <= B_MUL;
          end
        end
        B_DIVS: begin
          state_r <= B_DIVW;
        end
        B_DIVW: begin
          if (div_done) begin
            r_r     <= div_q;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          acc_r <= (acc_r << 16) + ACC_W'(slice_prod);
          if (mj_r == 2'd0) begin
            state_r <= B_OUT;
          end else begin
            mj_r <= mj_r - 2'd1;
          end
        end
        B_OUT: begin
          if (slot_free) begin
            out_grad_a        <= ga;
            out_grad_b        <= gb;
            out_pixel_dist_sq <= desc.dsq[39:0];
            out_batch_loss    <= (last_r && desc.last_b) ? desc.bl : '0;
            out_loss_valid    <= last_r && desc.last_b;
            out_last_of_pixel <= last_r;
            if (last_r) begin
              state_r <= B_IDLE;
            end else begin
              k_r     <= k_r + CNT_W'(1);
              state_r <= B_RD;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/dense_contrastive_loss_core.sv
// Dense contrastive loss, per pixel, with gradient output.
// Input channel: one word per channel element (feat_a, feat_b, similar,
// last_of_batch), taken on push while full is low. A pixel closes when the
// configured channel count is reached or last_of_batch is seen.
// Result channel: one word per channel of a closed pixel, oldest first,
// read with pop while empty is low. A stalled result simply waits in the
// output register; the front end keeps taking the next pixel meanwhile
// while the pixel queue has room. Input rate is one word per cycle inside
// a pixel unless the queue is full. Closing a pixel runs the front end
// through a 29-step square root, the hinge multiply and the loss update,
// plus the batch divide on the last pixel. A result for a dissimilar pair
// inside the margin goes through the 48-step ratio divider in the back end.
// Two diff-store banks and a two-entry pixel queue let one pixel drain
// while the next is collected.
// Configuration writes take effect on the next edge and should be made
// while the block is idle. Reset empties the queue and the output
// register, clears the accumulators and loads the register defaults.
module dense_contrastive_loss_core #(
  parameter int MAX_CHANNELS = dcl_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [15:0]                  in_feat_a,
  input  logic signed [15:0]                  in_feat_b,
  input  logic                                in_similar,
  input  logic                                in_last_of_batch,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [31:0]                  out_grad_a,
  output logic signed [31:0]                  out_grad_b,
  output logic [39:0]                         out_pixel_dist_sq,
  output logic [46:0]                         out_batch_loss,
  output logic                                out_loss_valid,
  output logic                                out_last_of_pixel,
  input  logic                                cfg_we,
  input  logic [dcl_pkg::CFG_A_W-1:0]         cfg_addr,
  input  logic [dcl_pkg::CFG_W-1:0]           cfg_wdata
);

  import dcl_pkg::*;

  localparam int AW = $clog2(2 * MAX_CHANNELS);

  logic [MARG_W-1:0] margin_r;
  logic [GS_W-1:0]   grad_scale_r;
  logic [NS_W-1:0]   num_samples_r;
  logic [CNT_W-1:0]  channels_r;

  pix_desc_t         q_mem_r [2];
  logic              q_wp_r;
  logic              q_rp_r;
  logic [1:0]        q_cnt_r;

  logic              push;
  logic              pop;
  pix_desc_t         push_desc;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [D_W-1:0]    ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [D_W-1:0]    ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r      <= MARG_W'(256);
      grad_scale_r  <= '0;
      num_samples_r <= NS_W'(1);
      channels_r    <= CNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MARGIN:     margin_r      <= cfg_wdata[MARG_W-1:0];
        REG_GRAD_SCALE: grad_scale_r  <= cfg_wdata[GS_W-1:0];
        REG_NUM_SAMP:   num_samples_r <= cfg_wdata[NS_W-1:0];
        REG_CHANNELS:   channels_r    <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Two-entry queue of closed pixels between the two halves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      if (push) begin
        q_mem_r[q_wp_r] <= push_desc;
        q_wp_r          <= ~q_wp_r;
      end
      if (pop) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  dcl_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_feat_a        (in_feat_a),
    .in_feat_b        (in_feat_b),
    .in_similar       (in_similar),
    .in_last_of_batch (in_last_of_batch),
    .margin           (margin_r),
    .num_samples      (num_samples_r),
    .channels_in_use  (channels_r),
    .q_count          (q_cnt_r),
    .push             (push),
    .desc             (push_desc),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata)
  );

  dcl_ram #(.WIDTH(D_W), .DEPTH(2 * MAX_CHANNELS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dcl_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .grad_scale        (grad_scale_r),
    .q_valid           (q_cnt_r != 2'd0),
    .desc              (q_mem_r[q_rp_r]),
    .pop               (pop),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_grad_a        (out_grad_a),
    .out_grad_b        (out_grad_b),
    .out_pixel_dist_sq (out_pixel_dist_sq),
    .out_batch_loss    (out_batch_loss),
    .out_loss_valid    (out_loss_valid),
    .out_last_of_pixel (out_last_of_pixel)
  );

endmodule

FILE: rtl/dcl_checker.sv
module dcl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_grad_a,
  input logic signed [31:0] out_grad_b,
  input logic [46:0]        out_batch_loss,
  input logic               out_loss_valid,
  input logic               out_last_of_pixel
);

  // The result register comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> out_empty)
    else $error("result word present right after reset");

  // A batch loss word always closes a pixel.
  a_loss_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_loss_valid) |-> out_last_of_pixel)
    else $error("loss_valid without last_of_pixel");

  // The batch loss field is zero on every other word.
  a_loss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_loss_valid) |-> (out_batch_loss == 47'd0))
    else $error("batch_loss nonzero without loss_valid");

  // Both gradients come from one magnitude, so a zero gradient is zero on both.
  a_grad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_grad_a == 32'sd0) |-> (out_grad_b == 32'sd0))
    else $error("grad_b nonzero while grad_a is zero");

  // A waiting result word holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_grad_a)))
    else $error("result word changed while stalled");

endmodule

bind dense_contrastive_loss_core dcl_checker u_dcl_checker (.*);

FILE: tb/dcl_checker.sv
`timescale 1ns / 100ps

// Watches the input and result channels of the loss core, predicts the
// gradient words for each closed pixel and compares them in order.
module dcl_tb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic signed [15:0] in_feat_a,
  input  logic signed [15:0] in_feat_b,
  input  logic               in_similar,
  input  logic               in_last_of_batch,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [31:0] out_grad_a,
  input  logic signed [31:0] out_grad_b,
  input  logic [39:0]        out_pixel_dist_sq,
  input  logic [46:0]        out_batch_loss,
  input  logic               out_loss_valid,
  input  logic               out_last_of_pixel,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 words_pending
);
  import dcl_pkg::*;

  typedef struct packed {
    logic [31:0] grad_a;
    logic [31:0] grad_b;
    logic [39:0] dist_sq;
    logic [46:0] loss;
    logic        loss_valid;
    logic        last_pix;
  } grad_word_t;

  grad_word_t grad_q[$];

  // Shadow copies of the registers and the pixel state.
  logic [15:0] margin_r;
  logic [31:0] scale_r;
  logic [15:0] samples_r;
  logic [6:0]  chan_r;
  logic signed [16:0] diffs[64];
  int unsigned pix_count;
  logic [63:0] dist_sum;
  logic [63:0] loss_sum;
  logic        label_r;

  assign words_pending = grad_q.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Saturate a signed magnitude to 32 bits.
  function automatic logic [31:0] sat_q(input logic [63:0] mag, input logic neg);
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // Close a pixel: update the loss and queue one word per channel.
  task automatic close_pixel(input logic last_b);
    logic [63:0] root_q, mq, m, term, gsm, den, bl, dm, r, mag;
    logic gneg, neg;
    int unsigned ns;
    grad_word_t w;
    m = 0;
    term = 0;
    root_q = int_sqrt(dist_sum << 16);
    mq = 64'(margin_r) << 8;
    if (label_r) term = dist_sum;
    else if (mq > root_q) begin
      m = mq - root_q;
      term = (m * m + 64'h8000) >> 16;
    end
    loss_sum = loss_sum + term;
    if (loss_sum > 64'hFFFF_FFFF_FFFF) loss_sum = 64'hFFFF_FFFF_FFFF;
    gneg = scale_r[31];
    gsm = gneg ? 64'(32'(-scale_r)) : 64'(scale_r);
    if (scale_r == 32'h8000_0000) gsm = 64'h8000_0000;
    den = root_q + 7;
    ns = (samples_r == 0) ? 1 : samples_r;
    bl = loss_sum / (2 * 64'(ns));
    for (int k = 0; k < pix_count; k++) begin
      dm = 64'(diffs[k] < 0 ? -diffs[k] : diffs[k]);
      r = 0;
      neg = 0;
      if (label_r) begin
        r = dm << 8;
        neg = gneg != diffs[k][16];
      end else if (m > 0) begin
        r = ((m * dm) << 8) / den;
        neg = gneg == diffs[k][16];
      end
      mag = (r >> 16) * gsm + (((r & 64'hFFFF) * gsm + 64'h8000) >> 16);
      w.grad_a = sat_q(mag, neg);
      w.grad_b = sat_q(mag, !neg);
      w.dist_sq = dist_sum[39:0];
      w.last_pix = (k + 1 == pix_count);
      w.loss_valid = w.last_pix && last_b;
      w.loss = w.loss_valid ? bl[46:0] : '0;
      grad_q.push_back(w);
    end
    pix_count = 0;
    dist_sum = 0;
    if (last_b) loss_sum = 0;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= 256;
      scale_r <= 0;
      samples_r <= 1;
      chan_r <= 64;
      pix_count = 0;
      dist_sum = 0;
      loss_sum = 0;
      label_r = 0;
      grad_q.delete();
      fail_count = 0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_addr)
          REG_MARGIN: begin
            margin_r <= cfg_wdata[15:0];
          end
          REG_GRAD_SCALE: begin
            scale_r <= cfg_wdata;
          end
          REG_NUM_SAMP: begin
            samples_r <= cfg_wdata[15:0];
          end
          REG_CHANNELS: begin
            chan_r <= cfg_wdata[6:0];
          end
          default: begin
          end
        endcase
      end
      // Accepted input word.
      if (in_push && !in_full) begin
        int unsigned lim;
        logic signed [16:0] d;
        lim = (chan_r == 0) ? 1 : (chan_r > 64 ? 64 : chan_r);
        d = 17'(in_feat_a) - 17'(in_feat_b);
        if (pix_count == 0) label_r = in_similar;
        if (pix_count >= 64) pix_count = 63;
        diffs[pix_count] = d;
        dist_sum = dist_sum + 64'(d) * 64'(d);
        pix_count++;
        if (pix_count >= lim || in_last_of_batch) close_pixel(in_last_of_batch);
      end
      // Accepted result word.
      if (out_pop && !out_empty) begin
        grad_word_t e;
        if (grad_q.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          e = grad_q.pop_front();
          if (out_grad_a !== e.grad_a) report("grad_a", out_grad_a, e.grad_a);
          if (out_grad_b !== e.grad_b) report("grad_b", out_grad_b, e.grad_b);
          if (out_pixel_dist_sq !== e.dist_sq)
            report("pixel_dist_sq", out_pixel_dist_sq, e.dist_sq);
          if (out_batch_loss !== e.loss) report("batch_loss", out_batch_loss, e.loss);
          if (out_loss_valid !== e.loss_valid)
            report("loss_valid", out_loss_valid, e.loss_valid);
          if (out_last_of_pixel !== e.last_pix)
            report("last_of_pixel", out_last_of_pixel, e.last_pix);
        end
      end
    end
  end

endmodule

FILE: tb/tb_dense_contrastive_loss_core.sv
`timescale 1ns / 100ps

module tb_dense_contrastive_loss_core;
  import dcl_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_full;
  logic signed [15:0] in_feat_a = 0;
  logic signed [15:0] in_feat_b = 0;
  logic in_similar = 0;
  logic in_last_of_batch = 0;
  logic out_empty;
  logic out_pop = 0;
  logic signed [31:0] out_grad_a, out_grad_b;
  logic [39:0] out_pixel_dist_sq;
  logic [46:0] out_batch_loss;
  logic out_loss_valid, out_last_of_pixel;
  logic cfg_we = 0;
  logic [CFG_A_W-1:0] cfg_addr = 0;
  logic [CFG_W-1:0] cfg_wdata = 0;
  int fail_count, words_pending;
  int idle_cycles = 0;
  int pop_gap = 0;
  logic [6:0] chan_now = 64;

  localparam int IDLE_LIMIT = 20000;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  dense_contrastive_loss_core dut (.*);

  dcl_tb_checker chk (.*);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random feature value, often at an extreme.
  function automatic logic [15:0] feat_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: pop, then stall for a random number of cycles.
  always @(negedge clk) begin
    if (rst_n) begin
      if (pop_gap > 0) begin
        out_pop <= 0;
        pop_gap <= pop_gap - 1;
      end else begin
        out_pop <= 1;
        pop_gap <= gap_len();
      end
    end
  end

  // Watchdog on accepted traffic.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(input logic [15:0] a, input logic [15:0] b,
                      input logic sim, input logic lob);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_push <= 0;
      repeat (g) @(negedge clk);
    end
    in_push <= 1;
    in_feat_a <= a;
    in_feat_b <= b;
    in_similar <= sim;
    in_last_of_batch <= lob;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_push <= 0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [31:0] v);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_CHANNELS) chan_now = v[6:0];
  endtask

  // One pixel of random content; the batch may end on its last word.
  task automatic send_pixel(input logic sim, input logic lob, input int words);
    for (int i = 0; i < words; i++)
      send(feat_val(), feat_val(), $urandom_range(0, 1) ? sim : ~sim,
           lob && (i == words - 1));
  endtask

  initial begin
    int lim;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: small pixels, extremes, both labels, hinge on and off.
    write_reg(REG_CHANNELS, 2);
    write_reg(REG_GRAD_SCALE, 32'h0001_0000);
    send(16'h7FFF, 16'h8000, 1, 0);
    send(16'h8000, 16'h7FFF, 1, 0);
    send(16'h0100, 16'h0100, 0, 0);
    send(16'h0000, 16'h0010, 0, 1);
    send(16'h0000, 16'h0000, 0, 0);
    send(16'h0000, 16'h0000, 0, 1);
    send(16'h7FFF, 16'h8000, 0, 1);
    drain();
    write_reg(REG_MARGIN, 16'hFFFF);
    write_reg(REG_GRAD_SCALE, 32'h8000_0000);
    write_reg(REG_NUM_SAMP, 0);
    write_reg(REG_CHANNELS, 0);
    send(16'h0010, 16'h0000, 0, 0);
    send(16'h8000, 16'h0000, 0, 1);
    send(16'h0005, 16'h0003, 1, 1);
    drain();
    write_reg(REG_GRAD_SCALE, 32'h7FFF_FFFF);
    write_reg(REG_NUM_SAMP, 16'hFFFF);
    write_reg(REG_CHANNELS, 7'd127);
    send_pixel(1, 0, 64);
    send_pixel(0, 1, 3);
    drain();
    write_reg(REG_MARGIN, 0);
    write_reg(REG_CHANNELS, 3);
    send_pixel(0, 1, 3);
    drain();

    // Random phases with new settings.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_MARGIN, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 4096));
      write_reg(REG_GRAD_SCALE, $urandom);
      write_reg(REG_NUM_SAMP, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                        : $urandom_range(1, 8));
      write_reg(REG_CHANNELS, $urandom_range(1, 5));
      lim = chan_now;
      for (int p = 0; p < 4; p++)
        send_pixel($urandom_range(0, 1), (p == 3) || ($urandom_range(0, 5) == 0),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, lim) : lim);
      drain();
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dcl_pkg.sv
rtl/dcl_ram.sv
rtl/dcl_div.sv
rtl/dcl_front.sv
rtl/dcl_back.sv
rtl/dense_contrastive_loss_core.sv
rtl/dcl_checker.sv
tb/dcl_checker.sv
tb/tb_dense_contrastive_loss_core.sv
